>>> rtl/core/rgbe_scanline_encoder_assert.svh
// Assertion macros for the RGBE scanline encoder.
// Used by rgbe_scanline_encoder.sv; expects i_clk and i_rst_n in scope.
`ifndef RGBE_SCANLINE_ENCODER_ASSERT_SVH
`define RGBE_SCANLINE_ENCODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// cond must hold at every clock out of reset
`define RSE_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("rse assertion failed");
// pre at one edge implies post at the next edge
`define RSE_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("rse assertion failed");
`else
`define RSE_ASSERT_ALWAYS(lbl, cond)
`define RSE_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> rtl/core/rse_pkg.sv
// Shared types and constants of the RGBE scanline encoder.
// No dependencies.
`timescale 1ns / 1ps
package rse_pkg;
    localparam int MAX_WIDTH = 4096;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int COL_W     = 13;
    localparam int CHUNK_MAX = 127;

    typedef struct packed {
        logic        action;
        logic [31:0] red_bits;
        logic [31:0] green_bits;
        logic [31:0] blue_bits;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] status;
        logic       row_end;
    } t_out_word;

    typedef enum logic [1:0] {
        ST_STORED  = 2'd0,
        ST_REFUSED = 2'd1,
        ST_BYTE    = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        PH_MAGIC0 = 3'd0,
        PH_MAGIC1 = 3'd1,
        PH_WID_HI = 3'd2,
        PH_WID_LO = 3'd3,
        PH_COUNT  = 3'd4,
        PH_DATA   = 3'd5
    } t_phase;

    localparam logic ACT_PIXEL = 1'b0;
endpackage

>>> rtl/core/rse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

>>> rtl/core/rgbe_scanline_encoder.sv
// Top level of the RGBE scanline encoder: pixel encode, line store, byte drain.
// Depends on rse_pkg, rse_ram and rgbe_scanline_encoder_assert.svh.
//
//  channel | signals                     | direction
//  --------+-----------------------------+----------
//  in      | i_in_valid/o_in_ready       | pixel or drain tick words in
//  out     | o_out_valid/i_out_ready     | one result word per input word
//  cfg     | i_cfg_valid/o_cfg_ready     | line width register write
//
// One input word per cycle unless stalled; the output register takes the result
// at accept. Pixels are encoded and written to the line store at accept; a data
// byte is read from the store at accept and its plane is picked at the output.
// Reset clears control state only; the line store holds no reset value.
// The input stalls only while the output register holds an untaken word.
`timescale 1ns / 1ps
`include "rgbe_scanline_encoder_assert.svh"
module rgbe_scanline_encoder
    import rse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);
    // control state
    logic [12:0]      r_line_width;
    logic [COL_W-1:0] r_fill_column, n_fill_column;
    logic             r_row_ready, n_row_ready;
    t_phase           r_phase, n_phase;
    logic [1:0]       r_plane, n_plane;
    logic [COL_W-1:0] r_drain_column, n_drain_column;
    logic [6:0]       r_chunk_left, n_chunk_left;

    // output register
    logic       r_out_valid;
    logic [7:0] r_byte, n_byte;
    t_status    r_status, n_status;
    logic       r_end, n_end;
    logic       r_from_mem, n_from_mem;
    logic [1:0] r_sel_plane;

    logic             accept;
    logic [COL_W-1:0] w;
    logic             mem_we, mem_re;
    logic [31:0]      enc_word, rd_word;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign accept      = i_in_valid && o_in_ready;

    // working width, clamped to [1, MAX_WIDTH]
    always_comb begin
        if (r_line_width == '0) begin
            w = COL_W'(1);
        end else if (r_line_width > COL_W'(MAX_WIDTH)) begin
            w = COL_W'(MAX_WIDTH);
        end else begin
            w = r_line_width;
        end
    end

    // ---------------- pixel encode ----------------
    function automatic logic [31:0] clean_ch(input logic [31:0] b);
        logic [31:0] res;
        if (b[31]) begin
            res = '0;
        end else if (b[30:23] == 8'hFF) begin
            res = (b[22:0] != '0) ? 32'h0 : 32'h7F7F_FFFF;
        end else begin
            res = b;
        end
        return res;
    endfunction

    // returns {mantissa, biased exponent} with subnormals at exponent 1
    function automatic logic [31:0] split_ch(input logic [31:0] b);
        logic [23:0] mant;
        logic [7:0]  ex;
        if (b[30:23] == 8'h00) begin
            mant = {1'b0, b[22:0]};
            ex   = 8'd1;
        end else begin
            mant = {1'b1, b[22:0]};
            ex   = b[30:23];
        end
        return {mant, ex};
    endfunction

    function automatic logic [7:0] ch_byte(input logic [31:0] b, input logic signed [9:0] e);
        logic [31:0]        sp;
        logic signed [10:0] s;
        logic [7:0]         res;
        sp = split_ch(b);
        s  = $signed({3'b000, sp[7:0]}) - 11'sd142 - 11'(e);
        if (s >= 0) begin
            if (s > 11'sd8) begin
                res = 8'hFF;
            end else begin
                res = 8'(sp[31:8] << s[3:0]);
            end
        end else if (s <= -11'sd32) begin
            res = 8'h00;
        end else begin
            res = 8'(sp[31:8] >> 5'(-s));
        end
        return res;
    endfunction

    logic [31:0]        c_r, c_g, c_b, c_m, m_split;
    logic [4:0]         lead;
    logic signed [9:0]  enc_e;

    always_comb begin
        c_r = clean_ch(i_in_data.red_bits);
        c_g = clean_ch(i_in_data.green_bits);
        c_b = clean_ch(i_in_data.blue_bits);
        // positive floats order as unsigned integers
        c_m = c_r;
        if (c_g > c_m) c_m = c_g;
        if (c_b > c_m) c_m = c_b;
        m_split = split_ch(c_m);
        lead = '0;
        for (int i = 1; i < 24; i++) begin
            if (m_split[8+i]) lead = 5'(i);
        end
        enc_e = $signed({5'b0, lead}) + $signed({2'b0, m_split[7:0]}) - 10'sd149;
        if (m_split[31:8] == '0 || enc_e <= -10'sd52) begin
            enc_word = '0;
        end else begin
            enc_word = {8'(enc_e + 10'sd128), ch_byte(c_b, enc_e),
                        ch_byte(c_g, enc_e), ch_byte(c_r, enc_e)};
        end
    end

    // ---------------- step control ----------------
    logic [COL_W-1:0] rem;
    logic [6:0]       chunk_dec;

    always_comb begin
        n_fill_column  = r_fill_column;
        n_row_ready    = r_row_ready;
        n_phase        = r_phase;
        n_plane        = r_plane;
        n_drain_column = r_drain_column;
        n_chunk_left   = r_chunk_left;
        n_byte         = '0;
        n_status       = ST_EMPTY;
        n_end          = 1'b0;
        n_from_mem     = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        rem            = (r_drain_column < w) ? (w - r_drain_column) : '0;
        if (rem > COL_W'(CHUNK_MAX)) rem = COL_W'(CHUNK_MAX);
        chunk_dec = (r_chunk_left != '0) ? (r_chunk_left - 7'd1) : '0;

        if (i_in_data.action == ACT_PIXEL) begin
            if (r_row_ready) begin
                n_status = ST_REFUSED;
            end else begin
                n_status = ST_STORED;
                mem_we   = accept;
                if (r_fill_column + COL_W'(1) >= w) begin
                    n_fill_column  = '0;
                    n_row_ready    = 1'b1;
                    n_phase        = PH_MAGIC0;
                    n_plane        = '0;
                    n_drain_column = '0;
                    n_chunk_left   = '0;
                end else begin
                    n_fill_column = r_fill_column + COL_W'(1);
                end
            end
        end else if (r_row_ready) begin
            n_status = ST_BYTE;
            unique case (r_phase)
                PH_MAGIC0, PH_MAGIC1: begin
                    n_byte  = 8'd2;
                    n_phase = (r_phase == PH_MAGIC0) ? PH_MAGIC1 : PH_WID_HI;
                end
                PH_WID_HI: begin
                    n_byte  = 8'(w >> 8);
                    n_phase = PH_WID_LO;
                end
                PH_WID_LO: begin
                    n_byte  = w[7:0];
                    n_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    n_byte = rem[7:0];
                    if (rem == '0) begin
                        n_drain_column = '0;
                        n_chunk_left   = '0;
                        if (r_plane == 2'd3) begin
                            n_end       = 1'b1;
                            n_plane     = '0;
                            n_phase     = PH_MAGIC0;
                            n_row_ready = 1'b0;
                        end else begin
                            n_plane = r_plane + 2'd1;
                        end
                    end else begin
                        n_chunk_left = rem[6:0];
                        n_phase      = PH_DATA;
                    end
                end
                default: begin
                    // data byte: read now, plane picked at the output
                    mem_re         = accept;
                    n_from_mem     = 1'b1;
                    n_drain_column = r_drain_column + COL_W'(1);
                    n_chunk_left   = chunk_dec;
                    if (chunk_dec == '0) begin
                        if (r_drain_column + COL_W'(1) >= w) begin
                            n_drain_column = '0;
                            if (r_plane == 2'd3) begin
                                n_end       = 1'b1;
                                n_plane     = '0;
                                n_phase     = PH_MAGIC0;
                                n_row_ready = 1'b0;
                            end else begin
                                n_plane = r_plane + 2'd1;
                                n_phase = PH_COUNT;
                            end
                        end else begin
                            n_phase = PH_COUNT;
                        end
                    end
                end
            endcase
        end
    end

    // line store
    rse_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_line_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_fill_column[ADDR_W-1:0]),
        .i_wdata (enc_word),
        .i_re    (mem_re),
        .i_raddr (r_drain_column[ADDR_W-1:0]),
        .o_rdata (rd_word)
    );

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= 13'd4096;
            r_fill_column  <= '0;
            r_row_ready    <= 1'b0;
            r_phase        <= PH_MAGIC0;
            r_plane        <= '0;
            r_drain_column <= '0;
            r_chunk_left   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_line_width <= i_cfg_data;
            end
            if (accept) begin
                r_fill_column  <= n_fill_column;
                r_row_ready    <= n_row_ready;
                r_phase        <= n_phase;
                r_plane        <= n_plane;
                r_drain_column <= n_drain_column;
                r_chunk_left   <= n_chunk_left;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte      <= n_byte;
            r_status    <= n_status;
            r_end       <= n_end;
            r_from_mem  <= n_from_mem;
            r_sel_plane <= r_plane;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out_data.out_byte = r_from_mem ? rd_word[{r_sel_plane, 3'b000} +: 8] : r_byte;
    assign o_out_data.status   = r_status;
    assign o_out_data.row_end  = r_end;

    `RSE_ASSERT_ALWAYS(a_end_is_byte, !r_out_valid || !r_end || r_status == ST_BYTE)
    `RSE_ASSERT_ALWAYS(a_data_has_chunk, r_phase != PH_DATA || r_chunk_left != '0)
    `RSE_ASSERT_NEXT(a_accept_fills_out, accept, r_out_valid)
    `RSE_ASSERT_NEXT(a_end_clears_row, accept && n_end, !r_row_ready && r_phase == PH_MAGIC0)
endmodule

>>> dv/rgbe_scanline_encoder_checker.sv
// Scoreboard for the RGBE scanline encoder: watches the in, out and cfg channels,
// predicts each result word and compares it. Depends on rse_pkg.
`timescale 1ns / 1ps
module rgbe_scanline_encoder_checker
    import rse_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_word    i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_word   i_out_data,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [12:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    logic [31:0] rgbe_row [MAX_WIDTH];
    logic [12:0] width_reg;
    int          fill_col;
    logic        row_full;
    t_phase      phase;
    int          plane;
    int          drain_col;
    int          chunk_rem;
    t_out_word   expected_words [$];

    assign o_pending = expected_words.size();

    // negatives and NaN to zero, +inf to largest finite
    function automatic logic [31:0] sanitize(logic [31:0] b);
        if (b[31]) return 32'd0;
        if (b[30:23] == 8'hFF) return (b[22:0] != 0) ? 32'd0 : 32'h7F7FFFFF;
        return b;
    endfunction

    function automatic void unpack_f32(logic [31:0] b, output logic [31:0] mant,
                                       output int ex);
        if (b[30:23] == 0) begin
            mant = {9'd0, b[22:0]};
            ex = 1;
        end else begin
            mant = {8'd0, 1'b1, b[22:0]};
            ex = b[30:23];
        end
    endfunction

    function automatic logic [7:0] scale_channel(logic [31:0] b, int e);
        logic [31:0] mant;
        int ex;
        int sh;
        unpack_f32(b, mant, ex);
        sh = ex - 142 - e;
        if (sh >= 0) begin
            if (sh > 8) return 8'hFF;
            return 8'(mant << sh);
        end
        if (sh <= -32) return 8'd0;
        return 8'(mant >> (-sh));
    endfunction

    function automatic logic [31:0] rgbe_word(logic [31:0] r, logic [31:0] g,
                                              logic [31:0] b);
        logic [31:0] mx;
        logic [31:0] mant;
        int ex;
        int p;
        int e;
        r = sanitize(r);
        g = sanitize(g);
        b = sanitize(b);
        mx = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        unpack_f32(mx, mant, ex);
        if (mant == 0) return 32'd0;
        p = 0;
        while (p < 23 && (mant >> (p + 1)) != 0) p++;
        e = p + ex - 149;
        if (e <= -52) return 32'd0;
        return {8'(e + 128), scale_channel(b, e), scale_channel(g, e),
                scale_channel(r, e)};
    endfunction

    function automatic logic next_plane();
        drain_col = 0;
        chunk_rem = 0;
        if (plane >= 3) begin
            plane = 0;
            phase = PH_MAGIC0;
            row_full = 1'b0;
            return 1'b1;
        end
        plane++;
        phase = PH_COUNT;
        return 1'b0;
    endfunction

    function automatic t_out_word predict_word(t_in_word w);
        t_out_word res;
        int wd;
        int rem;
        wd = (width_reg < 1) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        res = '0;
        if (w.action == ACT_PIXEL) begin
            if (row_full) res.status = ST_REFUSED;
            else begin
                if (fill_col < MAX_WIDTH)
                    rgbe_row[fill_col] = rgbe_word(w.red_bits, w.green_bits, w.blue_bits);
                if (fill_col + 1 >= wd) begin
                    fill_col = 0;
                    row_full = 1'b1;
                    phase = PH_MAGIC0;
                    plane = 0;
                    drain_col = 0;
                    chunk_rem = 0;
                end else fill_col++;
                res.status = ST_STORED;
            end
        end else if (!row_full) begin
            res.status = ST_EMPTY;
        end else begin
            res.status = ST_BYTE;
            case (phase)
                PH_MAGIC0, PH_MAGIC1: begin
                    res.out_byte = 8'd2;
                    phase = t_phase'(phase + 1);
                end
                PH_WID_HI: begin
                    res.out_byte = 8'(wd >> 8);
                    phase = PH_WID_LO;
                end
                PH_WID_LO: begin
                    res.out_byte = 8'(wd);
                    phase = PH_COUNT;
                end
                PH_COUNT: begin
                    rem = (drain_col < wd) ? wd - drain_col : 0;
                    if (rem > CHUNK_MAX) rem = CHUNK_MAX;
                    res.out_byte = 8'(rem);
                    if (rem == 0) res.row_end = next_plane();
                    else begin
                        chunk_rem = rem;
                        phase = PH_DATA;
                    end
                end
                default: begin
                    res.out_byte = 8'(rgbe_row[drain_col] >> (plane * 8));
                    drain_col++;
                    if (chunk_rem > 0) chunk_rem--;
                    if (chunk_rem == 0) begin
                        if (drain_col >= wd) res.row_end = next_plane();
                        else phase = PH_COUNT;
                    end
                end
            endcase
        end
        return res;
    endfunction

    // track state, queue predictions, compare results
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            width_reg <= 13'd4096;
            fill_col = 0;
            row_full = 1'b0;
            phase = PH_MAGIC0;
            plane = 0;
            drain_col = 0;
            chunk_rem = 0;
            expected_words.delete();
            o_fail_count <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word %p", i_out_data);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_w = expected_words.pop_front();
                    if (exp_w != i_out_data) begin
                        if (exp_w.out_byte != i_out_data.out_byte)
                            $error("out_byte expected %0d actual %0d",
                                   exp_w.out_byte, i_out_data.out_byte);
                        if (exp_w.status != i_out_data.status)
                            $error("status expected %0d actual %0d",
                                   exp_w.status, i_out_data.status);
                        if (exp_w.row_end != i_out_data.row_end)
                            $error("row_end expected %0d actual %0d",
                                   exp_w.row_end, i_out_data.row_end);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_words.insert(expected_words.size(), predict_word(i_in_data));
            if (i_cfg_valid && i_cfg_ready) width_reg <= i_cfg_data;
        end
    end
endmodule

>>> dv/rgbe_scanline_encoder_tb.sv
// Testbench top for the RGBE scanline encoder: clock, reset, stimulus, verdict.
// Depends on rse_pkg, rgbe_scanline_encoder and rgbe_scanline_encoder_checker.
`timescale 1ns / 1ps
module rgbe_scanline_encoder_tb;
    import rse_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_in_word    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_word   out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          row_width = 4096;
    logic        stall_on = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    rgbe_scanline_encoder dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    rgbe_scanline_encoder_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(5, 30);
        if ($urandom_range(0, 1) == 0) return 0;
        return $urandom_range(1, 3);
    endfunction

    // receiver stalls, with quiet stretches
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("status: fail");
            $finish;
        end
        if (cycle_count % 500 == 0) stall_on <= $urandom_range(0, 2) != 0;
        out_ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // random channel pattern, mostly ordinary magnitudes
    function automatic logic [31:0] rand_channel();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return {1'b0, $urandom_range(0, 255) == 0 ? 8'hFF : 8'($urandom),
                       23'($urandom)};
            2: return {1'b0, 8'($urandom_range(0, 80)), 23'($urandom)};
            3: return {1'b1, 31'($urandom)};
            default: return {1'b0, 8'($urandom_range(100, 150)), 23'($urandom)};
        endcase
    endfunction

    // valid stays high after the accept; the next word or an idle step drops it
    task automatic send_word(logic act, logic [31:0] r, logic [31:0] g, logic [31:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= '{action: act, red_bits: r, green_bits: g, blue_bits: b};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    task automatic set_width(int w);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= 13'(w);
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        row_width = (w < 1) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    endtask

    // one full row plus enough drain ticks, with a few stray words
    task automatic send_row();
        int ticks;
        for (int i = 0; i < row_width; i++) begin
            send_word(ACT_PIXEL, rand_channel(), rand_channel(), rand_channel());
            if ($urandom_range(0, 15) == 0) send_word(1'b1, $urandom, $urandom, $urandom);
        end
        ticks = 4 + 4 * (row_width + (row_width + 126) / 127);
        for (int i = 0; i < ticks; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_word(ACT_PIXEL, $urandom, $urandom, $urandom);
            send_word(1'b1, $urandom, $urandom, $urandom);
        end
    endtask

    initial begin
        int widths [5] = '{3, 1, 0, 5, 8191};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed: empty drain, specials in one row of width 8
        send_word(1'b1, 0, 0, 0);
        set_width(8);
        send_word(ACT_PIXEL, 32'h00000000, 32'h80000000, 32'hFF800000);
        send_word(ACT_PIXEL, 32'h7F800000, 32'h7FC00000, 32'h3F800000);
        send_word(ACT_PIXEL, 32'hFFFFFFFF, 32'h7F7FFFFF, 32'h00000001);
        send_word(ACT_PIXEL, 32'h00800000, 32'h00400000, 32'h25000000);
        send_word(ACT_PIXEL, 32'h3F7FFFFF, 32'h3F000000, 32'h3E800000);
        send_word(ACT_PIXEL, 32'h7F000000, 32'h00000000, 32'h00000000);
        send_word(ACT_PIXEL, 32'h25800000, 32'h25000001, 32'h24FFFFFF);
        send_word(ACT_PIXEL, 32'h40490FDB, 32'h00000000, 32'h3DCCCCCD);
        send_word(ACT_PIXEL, 32'h3F800000, 32'h3F800000, 32'h3F800000);
        for (int i = 0; i < 4 + 4 * 9; i++) send_word(1'b1, 0, 0, 0);
        // random rows across widths; width shrinks mid-fill once
        foreach (widths[k]) begin
            set_width(widths[k]);
            if (row_width > 200) begin
                // large width: fill partly, shrink mid-row to finish
                for (int i = 0; i < 10; i++)
                    send_word(ACT_PIXEL, rand_channel(), rand_channel(), rand_channel());
                set_width(6);
            end
            send_row();
        end
        // width shrunk mid-drain, right before the second count byte of plane 0
        set_width(130);
        for (int i = 0; i < 130; i++)
            send_word(ACT_PIXEL, rand_channel(), rand_channel(), rand_channel());
        for (int i = 0; i < 4 + 1 + CHUNK_MAX; i++) send_word(1'b1, 0, 0, 0);
        set_width(4);
        for (int i = 0; i < 20; i++) send_word(1'b1, 0, 0, 0);
        set_width(2);
        send_row();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/rse_pkg.sv
rtl/core/rse_ram.sv
rtl/core/rgbe_scanline_encoder.sv
dv/rgbe_scanline_encoder_checker.sv
dv/rgbe_scanline_encoder_tb.sv
